// ----- sv/dslp_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the lax DER signature parser.
// Depends on nothing; every other file of the block imports it.
package dslp_pkg;

    localparam int INT_BYTES        = 32;
    localparam int LEN_OF_LEN_LIMIT = 8;
    localparam int VALUE_W          = 8 * INT_BYTES;
    localparam int WORD_W           = 64;
    localparam int WORDS            = 2 * VALUE_W / WORD_W;
    localparam int IDX_W            = $clog2(WORDS);
    localparam int DIGIT_W          = 6;
    localparam int IN_TDATA_W       = 8;
    localparam int OUT_TDATA_W      = 72;
    localparam int OUT_TUSER_W      = 2;

    localparam logic [7:0] SEQ_TAG  = 8'h30;
    localparam logic [7:0] INT_TAG  = 8'h02;

    localparam logic [VALUE_W-1:0] GROUP_ORDER =
        256'hFFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFE_BAAEDCE6_AF48A03B_BFD25E8C_D0364141;

    typedef enum logic [3:0] {
        PH_SEQ_TAG,
        PH_SEQ_LEN,
        PH_SEQ_SKIP,
        PH_R_TAG,
        PH_R_LEN,
        PH_R_LONG,
        PH_R_BODY,
        PH_S_TAG,
        PH_S_LEN,
        PH_S_LONG,
        PH_S_BODY,
        PH_DONE
    } phase_t;

    // Parse outcome handed from the parser to the emitter on a final byte.
    typedef struct packed {
        logic               ok;
        logic               r_over;
        logic               s_over;
        logic [VALUE_W-1:0] r_value;
        logic [VALUE_W-1:0] s_value;
    } sig_result_t;

endpackage

// ----- sv/dslp_parser.sv -----
`timescale 1ns / 1ps
// Byte-wide DER parse state machine: tags, lengths and the R and S shift registers.
// Depends on dslp_pkg.
module dslp_parser #(
    parameter int unsigned MAX_STREAM_BYTES = 65535
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  logic [7:0]           data_byte,
    input  logic                 last_byte,
    output dslp_pkg::sig_result_t result
);
    import dslp_pkg::*;

    localparam int LEN_W = $clog2(MAX_STREAM_BYTES + 1);

    phase_t               phase_reg, phase_next;
    logic [LEN_W-1:0]     lc_reg, lc_next;
    logic [7:0]           lol_reg, lol_next;
    logic [VALUE_W-1:0]   r_reg, r_next, s_reg, s_next;
    logic [DIGIT_W-1:0]   rd_reg, rd_next, sd_reg, sd_next;
    logic                 seen_reg, seen_next;
    logic                 failed_reg, failed_next;

    always_comb
    begin
        logic                 second;
        phase_t               body_phase;
        phase_t               skip_phase;
        logic [LEN_W+7:0]     t_len;
        logic [LEN_W-1:0]     lc_dec;
        logic [LEN_W-1:0]     lc_sat;
        logic [7:0]           lol_dec;
        logic [VALUE_W-1:0]   v_cur;
        logic [DIGIT_W-1:0]   d_cur;

        phase_next  = phase_reg;
        lc_next     = lc_reg;
        lol_next    = lol_reg;
        r_next      = r_reg;
        s_next      = s_reg;
        rd_next     = rd_reg;
        sd_next     = sd_reg;
        seen_next   = seen_reg;
        failed_next = failed_reg;

        second     = (phase_reg == PH_S_LEN) || (phase_reg == PH_S_LONG) ||
                     (phase_reg == PH_S_BODY);
        body_phase = second ? PH_S_BODY : PH_R_BODY;
        skip_phase = second ? PH_DONE : PH_S_TAG;
        t_len      = {lc_reg, data_byte};
        lc_dec     = lc_reg - LEN_W'(1);
        lc_sat     = (t_len > (LEN_W + 8)'(MAX_STREAM_BYTES)) ?
                     LEN_W'(MAX_STREAM_BYTES) : t_len[LEN_W-1:0];
        lol_dec    = lol_reg - 8'd1;
        v_cur      = second ? s_reg : r_reg;
        d_cur      = second ? sd_reg : rd_reg;

        if (!failed_reg)
        begin
            case (phase_reg)
                PH_SEQ_TAG:
                begin
                    if (data_byte != SEQ_TAG)
                        failed_next = 1'b1;
                    else
                        phase_next = PH_SEQ_LEN;
                end
                PH_SEQ_LEN:
                begin
                    // The sequence length is only skipped, and only its long form has bytes.
                    if (data_byte[7] && (data_byte[6:0] != 7'd0))
                    begin
                        lc_next    = LEN_W'(data_byte[6:0]);
                        phase_next = PH_SEQ_SKIP;
                    end
                    else
                    begin
                        lc_next    = '0;
                        phase_next = PH_R_TAG;
                    end
                end
                PH_SEQ_SKIP:
                begin
                    lc_next = lc_dec;
                    if (lc_dec == '0)
                        phase_next = PH_R_TAG;
                end
                PH_R_TAG, PH_S_TAG:
                begin
                    if (data_byte != INT_TAG)
                        failed_next = 1'b1;
                    else
                        phase_next = (phase_reg == PH_S_TAG) ? PH_S_LEN : PH_R_LEN;
                end
                PH_R_LEN, PH_S_LEN:
                begin
                    seen_next = 1'b0;
                    if (data_byte[7])
                    begin
                        lol_next = {1'b0, data_byte[6:0]};
                        lc_next  = '0;
                        phase_next = (data_byte[6:0] == 7'd0) ? skip_phase
                                                               : (second ? PH_S_LONG : PH_R_LONG);
                    end
                    else
                    begin
                        lc_next    = LEN_W'(data_byte[6:0]);
                        phase_next = (data_byte[6:0] == 7'd0) ? skip_phase : body_phase;
                    end
                end
                PH_R_LONG, PH_S_LONG:
                begin
                    if (!seen_reg && (data_byte == 8'd0))
                    begin
                        // Leading zero length bytes are dropped.
                        lol_next = lol_dec;
                        if (lol_dec == 8'd0)
                        begin
                            seen_next  = 1'b0;
                            phase_next = (lc_reg == '0) ? skip_phase : body_phase;
                        end
                    end
                    else if (!seen_reg && (lol_reg >= 8'(LEN_OF_LEN_LIMIT)))
                    begin
                        failed_next = 1'b1;
                    end
                    else
                    begin
                        seen_next = 1'b1;
                        lc_next   = lc_sat;
                        lol_next  = lol_dec;
                        if (lol_dec == 8'd0)
                        begin
                            seen_next  = 1'b0;
                            phase_next = (lc_sat == '0) ? skip_phase : body_phase;
                        end
                    end
                end
                PH_R_BODY, PH_S_BODY:
                begin
                    lc_next = lc_dec;
                    if (seen_reg || (data_byte != 8'd0))
                    begin
                        seen_next = 1'b1;
                        if (d_cur < DIGIT_W'(INT_BYTES))
                        begin
                            if (second)
                            begin
                                s_next  = {v_cur[VALUE_W-9:0], data_byte};
                                sd_next = d_cur + DIGIT_W'(1);
                            end
                            else
                            begin
                                r_next  = {v_cur[VALUE_W-9:0], data_byte};
                                rd_next = d_cur + DIGIT_W'(1);
                            end
                        end
                        else if (second)
                            sd_next = DIGIT_W'(INT_BYTES + 1);
                        else
                            rd_next = DIGIT_W'(INT_BYTES + 1);
                    end
                    if (lc_dec == '0)
                        phase_next = skip_phase;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign result.ok      = !failed_next && (phase_next == PH_DONE);
    assign result.r_over  = rd_next > DIGIT_W'(INT_BYTES);
    assign result.s_over  = sd_next > DIGIT_W'(INT_BYTES);
    assign result.r_value = r_next;
    assign result.s_value = s_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_SEQ_TAG;
            lc_reg     <= '0;
            lol_reg    <= '0;
            r_reg      <= '0;
            s_reg      <= '0;
            rd_reg     <= '0;
            sd_reg     <= '0;
            seen_reg   <= 1'b0;
            failed_reg <= 1'b0;
        end
        else if (step)
        begin
            if (last_byte)
            begin
                // The final byte hands its outcome over and rearms for the next signature.
                phase_reg  <= PH_SEQ_TAG;
                lc_reg     <= '0;
                lol_reg    <= '0;
                r_reg      <= '0;
                s_reg      <= '0;
                rd_reg     <= '0;
                sd_reg     <= '0;
                seen_reg   <= 1'b0;
                failed_reg <= 1'b0;
            end
            else
            begin
                phase_reg  <= phase_next;
                lc_reg     <= lc_next;
                lol_reg    <= lol_next;
                r_reg      <= r_next;
                s_reg      <= s_next;
                rd_reg     <= rd_next;
                sd_reg     <= sd_next;
                seen_reg   <= seen_next;
                failed_reg <= failed_next;
            end
        end
    end

    // A digit count never goes past the oversize mark.
    a_digit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (rd_reg <= DIGIT_W'(INT_BYTES + 1)) && (sd_reg <= DIGIT_W'(INT_BYTES + 1)))
        else $error("digit count beyond oversize mark");

    // Once a parse has failed, the values stop changing until the final byte.
    a_failed_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        failed_reg && step && !last_byte |=> $stable(r_reg) && $stable(s_reg))
        else $error("value changed after failure");

endmodule

// ----- sv/dslp_emitter.sv -----
`timescale 1ns / 1ps
// Snapshot register, group-order check and the eight-word output bank.
// Depends on dslp_pkg.
module dslp_emitter (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               capture,
    input  dslp_pkg::sig_result_t              result,
    output logic                               snap_full,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [dslp_pkg::OUT_TDATA_W-1:0]   m_tdata,   // sig_word, word_index, zero pad
    output logic [dslp_pkg::OUT_TUSER_W-1:0]   m_tuser,   // parse_ok, out_of_range
    output logic                               m_tlast
);
    import dslp_pkg::*;

    logic                          snap_valid_reg;
    sig_result_t                   snap_reg;
    logic                          bank_valid_reg;
    logic [WORDS-1:0][WORD_W-1:0]  bank_reg, bank_next;
    logic                          ok_reg, oor_reg, oor_next;
    logic [IDX_W-1:0]              idx_reg;
    logic                          word_taken, last_taken, bank_free, snap_adv;

    assign word_taken = m_tvalid && m_tready;
    assign last_taken = word_taken && (idx_reg == IDX_W'(WORDS - 1));
    assign bank_free  = !bank_valid_reg || last_taken;
    assign snap_adv   = snap_valid_reg && bank_free;
    assign snap_full  = snap_valid_reg;

    always_comb
    begin
        logic keep;
        oor_next = snap_reg.ok &&
                   (snap_reg.r_over || snap_reg.s_over ||
                    (snap_reg.r_value >= GROUP_ORDER) || (snap_reg.s_value >= GROUP_ORDER));
        keep = snap_reg.ok && !oor_next;
        for (int k = 0; k < WORDS / 2; k++)
        begin
            bank_next[k] = keep ?
                snap_reg.r_value[VALUE_W-1-k*WORD_W -: WORD_W] : '0;
            bank_next[k + WORDS / 2] = keep ?
                snap_reg.s_value[VALUE_W-1-k*WORD_W -: WORD_W] : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            snap_valid_reg <= 1'b0;
            bank_valid_reg <= 1'b0;
            idx_reg        <= '0;
        end
        else
        begin
            if (capture)
                snap_valid_reg <= 1'b1;
            else if (snap_adv)
                snap_valid_reg <= 1'b0;

            if (snap_adv)
            begin
                bank_valid_reg <= 1'b1;
                idx_reg        <= '0;
            end
            else if (last_taken)
            begin
                bank_valid_reg <= 1'b0;
                idx_reg        <= '0;
            end
            else if (word_taken)
                idx_reg <= idx_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (capture)
            snap_reg <= result;
        if (snap_adv)
        begin
            bank_reg <= bank_next;
            ok_reg   <= snap_reg.ok;
            oor_reg  <= oor_next;
        end
    end

    assign m_tvalid = bank_valid_reg;
    assign m_tdata  = {(OUT_TDATA_W - WORD_W - IDX_W)'(0), idx_reg, bank_reg[idx_reg]};
    assign m_tuser  = {oor_reg, ok_reg};
    assign m_tlast  = idx_reg == IDX_W'(WORDS - 1);

    a_oor_needs_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && oor_reg |-> ok_reg)
        else $error("out_of_range without parse_ok");

    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (!ok_reg || oor_reg) |-> (bank_reg[idx_reg] == '0))
        else $error("nonzero word on a rejected signature");

    a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
        word_taken && !m_tlast |=> m_tvalid && (idx_reg == $past(idx_reg) + IDX_W'(1)))
        else $error("word index did not advance");

    a_bank_drain: assert property (@(posedge clk) disable iff (!rst_n)
        last_taken && !snap_valid_reg |=> !m_tvalid)
        else $error("output valid after final word with nothing pending");

endmodule

// ----- sv/der_signature_lax_parser.sv -----
`timescale 1ns / 1ps
// Top level of the lax DER signature parser: input register, parser and output bank.
// Depends on dslp_pkg, dslp_parser and dslp_emitter.
//
//  Channel | Direction | tdata                         | tuser                   | tlast
//  s_*     | in        | [7:0] data_byte               | none                    | last_byte
//  m_*     | out       | [63:0] sig_word, [66:64] idx  | [0] parse_ok, [1] oor   | last_word
//
// One byte beat is taken per cycle unless a final byte is held. Each byte is parsed from
// the input register by the state machine and the R and S shift registers. A beat with
// tlast produces eight output beats; the first appears after the final byte passes the
// input register, the snapshot with group-order check and the output bank. While m_tready
// is high the output bank sends one word per cycle, so signatures shorter than eight
// bytes are limited by the output side. A final byte waits in the input register only
// while the previous signature's snapshot waits for the bank; other bytes never wait.
// Reset is asynchronous and active low, and leaves the parser expecting a sequence tag.
module der_signature_lax_parser #(
    parameter int unsigned MAX_STREAM_BYTES = 65535
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [dslp_pkg::IN_TDATA_W-1:0]    s_tdata,   // data_byte
    input  logic                               s_tlast,   // last_byte
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [dslp_pkg::OUT_TDATA_W-1:0]   m_tdata,   // sig_word, word_index, zero pad
    output logic [dslp_pkg::OUT_TUSER_W-1:0]   m_tuser,   // parse_ok, out_of_range
    output logic                               m_tlast    // last_word
);
    import dslp_pkg::*;

    logic              in_valid_reg;
    logic [7:0]        in_byte_reg;
    logic              in_last_reg;
    logic              step;
    logic              snap_full;
    sig_result_t       result;

    // A byte is parsed unless it ends a signature while the snapshot slot is still taken.
    assign step     = in_valid_reg && (!in_last_reg || !snap_full);
    assign s_tready = !in_valid_reg || step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tvalid && s_tready)
            in_valid_reg <= 1'b1;
        else if (step)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    dslp_parser #(
        .MAX_STREAM_BYTES(MAX_STREAM_BYTES)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .data_byte (in_byte_reg),
        .last_byte (in_last_reg),
        .result    (result)
    );

    dslp_emitter u_emitter (
        .clk       (clk),
        .rst_n     (rst_n),
        .capture   (step && in_last_reg),
        .result    (result),
        .snap_full (snap_full),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // A held byte stays put until the parser takes it.
    a_hold_byte: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !step |=> in_valid_reg && $stable(in_byte_reg) && $stable(in_last_reg))
        else $error("input register changed while stalled");

    // Only a final byte can be held back.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !step |-> in_last_reg && snap_full)
        else $error("input stalled without a pending snapshot");

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for der_signature_lax_parser: directed signature cases and random
// byte streams, checked beat by beat against a parse predictor. Depends on dslp_pkg and the RTL.
module testbench;
    import dslp_pkg::*;

    // The byte bound on declared lengths; the DUT gets the same value explicitly.
    localparam int unsigned STREAM_BOUND = 65535;
    // Cycles allowed after the last expected beat before the verdict; the pipeline is three deep.
    localparam int DRAIN_CYCLES = 16;
    // Hard bound on the run. The slowest legal run stays far below this.
    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_BYTES = 310;
    localparam int HOLD_CYCLES  = 400;

    // How the content of one integer element is made up.
    typedef enum logic [1:0] {
        VK_RANDOM,      // random bytes, the first one nonzero
        VK_ALL_FF,      // every byte 0xFF
        VK_ORDER,       // exactly the group order
        VK_ORDER_LESS   // the group order minus one, the largest accepted value
    } val_kind_t;

    // How the eight beats of a signature are predicted.
    typedef enum logic [1:0] {
        CHK_MODEL,      // from the predictor
        CHK_REJECT,     // parse_ok = 0, zero words
        CHK_OOR,        // parse_ok = 1, out_of_range = 1, zero words
        CHK_ZERO        // parse_ok = 1, both values zero
    } check_t;

    // One integer element: tag, content and the form of its length.
    typedef struct packed {
        logic [7:0] tag;
        val_kind_t  kind;
        logic [7:0] nbytes;     // significant content bytes (VK_RANDOM, VK_ALL_FF)
        logic [7:0] pad;        // leading zero content bytes
        logic       long_len;   // long-form length
        logic [7:0] len_pad;    // leading zero length bytes in long form
        logic [7:0] len_huge;   // nonzero: long form of this many 0xFF length bytes
    } int_spec_t;

    // One whole signature stream.
    typedef struct packed {
        logic [7:0] seq_tag;
        logic [7:0] seq_skip;   // 0: short sequence length, else long form skipping this many
        int_spec_t  r;
        int_spec_t  s;
        logic [7:0] trail;      // bytes after S
        logic [7:0] cut;        // nonzero: stream ends after this many bytes
        check_t     chk;
    } sig_spec_t;

    // One output beat as the predictor sees it.
    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic [IDX_W-1:0]  idx;
        logic              ok;
        logic              oor;
        logic              last;
    } sig_beat_t;

    localparam int_spec_t V_EMPTY      = '{INT_TAG, VK_RANDOM, 8'd0, 8'd0, 1'b0, 8'd0, 8'd0};
    localparam int_spec_t V_BYTE       = '{INT_TAG, VK_RANDOM, 8'd1, 8'd0, 1'b0, 8'd0, 8'd0};
    localparam int_spec_t V_WORD       = '{INT_TAG, VK_RANDOM, 8'd8, 8'd0, 1'b0, 8'd0, 8'd0};
    localparam int_spec_t V_FULL_PAD   = '{INT_TAG, VK_RANDOM, 8'd32, 8'd3, 1'b0, 8'd0, 8'd0};
    localparam int_spec_t V_FF32       = '{INT_TAG, VK_ALL_FF, 8'd32, 8'd0, 1'b0, 8'd0, 8'd0};
    localparam int_spec_t V_ORDER      = '{INT_TAG, VK_ORDER, 8'd32, 8'd0, 1'b0, 8'd0, 8'd0};
    localparam int_spec_t V_ORDER_LESS = '{INT_TAG, VK_ORDER_LESS, 8'd32, 8'd0, 1'b0, 8'd0, 8'd0};
    localparam int_spec_t V_OVER33     = '{INT_TAG, VK_RANDOM, 8'd33, 8'd0, 1'b0, 8'd0, 8'd0};
    localparam int_spec_t V_LONG_PAD7  = '{INT_TAG, VK_RANDOM, 8'd5, 8'd0, 1'b1, 8'd7, 8'd0};
    localparam int_spec_t V_INDEF      = '{INT_TAG, VK_RANDOM, 8'd0, 8'd0, 1'b1, 8'd0, 8'd0};
    localparam int_spec_t V_LOL_LIMIT  = '{INT_TAG, VK_RANDOM, 8'd3, 8'd0, 1'b0, 8'd0, 8'd8};
    localparam int_spec_t V_HUGE       = '{INT_TAG, VK_RANDOM, 8'd3, 8'd0, 1'b0, 8'd0, 8'd3};
    localparam int_spec_t V_FF40_LONG  = '{INT_TAG, VK_ALL_FF, 8'd40, 8'd0, 1'b1, 8'd0, 8'd0};
    localparam int_spec_t V_BAD_TAG    = '{8'h03, VK_RANDOM, 8'd1, 8'd0, 1'b0, 8'd0, 8'd0};

    // Directed cases. Rows whose outcome is plain are typed in; the rest go to the predictor.
    localparam int N_DIRECTED = 20;
    localparam sig_spec_t DIRECTED_CASES [N_DIRECTED] = '{
        // both values empty right after reset
        '{SEQ_TAG, 8'd0, V_EMPTY, V_EMPTY, 8'd0, 8'd0, CHK_ZERO},
        '{SEQ_TAG, 8'd0, V_BYTE, V_WORD, 8'd0, 8'd0, CHK_MODEL},
        // R of all ones is above the order
        '{SEQ_TAG, 8'd0, V_FF32, V_BYTE, 8'd0, 8'd0, CHK_OOR},
        // largest values that still pass
        '{SEQ_TAG, 8'd0, V_ORDER_LESS, V_ORDER_LESS, 8'd0, 8'd0, CHK_MODEL},
        // S equal to the order
        '{SEQ_TAG, 8'd0, V_BYTE, V_ORDER, 8'd0, 8'd0, CHK_OOR},
        // 33 significant bytes
        '{SEQ_TAG, 8'd0, V_OVER33, V_BYTE, 8'd0, 8'd0, CHK_OOR},
        // full-width values behind leading zero bytes
        '{SEQ_TAG, 8'd0, V_FULL_PAD, V_FULL_PAD, 8'd0, 8'd0, CHK_MODEL},
        // wrong sequence, R and S tags
        '{8'h31, 8'd0, V_BYTE, V_BYTE, 8'd0, 8'd0, CHK_REJECT},
        '{SEQ_TAG, 8'd0, V_BAD_TAG, V_BYTE, 8'd0, 8'd0, CHK_REJECT},
        '{SEQ_TAG, 8'd0, V_BYTE, V_BAD_TAG, 8'd0, 8'd0, CHK_REJECT},
        // stream ends on the S tag
        '{SEQ_TAG, 8'd0, V_WORD, V_WORD, 8'd0, 8'd13, CHK_REJECT},
        // seven zero length bytes in front, then an indefinite-looking 0x80 length
        '{SEQ_TAG, 8'd0, V_LONG_PAD7, V_INDEF, 8'd0, 8'd0, CHK_MODEL},
        // eight significant length bytes
        '{SEQ_TAG, 8'd0, V_LOL_LIMIT, V_BYTE, 8'd0, 8'd0, CHK_REJECT},
        // saturating declared length runs past the end of the stream
        '{SEQ_TAG, 8'd0, V_HUGE, V_BYTE, 8'd0, 8'd0, CHK_REJECT},
        // long-form sequence length that is skipped
        '{SEQ_TAG, 8'd3, V_BYTE, V_BYTE, 8'd0, 8'd0, CHK_MODEL},
        // trailing bytes after S
        '{SEQ_TAG, 8'd0, V_BYTE, V_BYTE, 8'd5, 8'd0, CHK_MODEL},
        // single-byte streams
        '{SEQ_TAG, 8'd0, V_BYTE, V_BYTE, 8'd0, 8'd1, CHK_REJECT},
        '{8'hFF, 8'd0, V_BYTE, V_BYTE, 8'd0, 8'd1, CHK_REJECT},
        '{8'h00, 8'd0, V_BYTE, V_BYTE, 8'd0, 8'd1, CHK_REJECT},
        // 40 bytes of 0xFF with a long-form length
        '{SEQ_TAG, 8'd0, V_FF40_LONG, V_EMPTY, 8'd0, 8'd0, CHK_OOR}
    };

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   s_tlast;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [OUT_TUSER_W-1:0] m_tuser;
    logic                   m_tlast;

    der_signature_lax_parser #(
        .MAX_STREAM_BYTES (STREAM_BOUND)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // Predictor state: a copy of the parser's own registers.
    phase_t             ph;
    int unsigned        len_cnt;
    logic [7:0]         lol;
    logic [VALUE_W-1:0] r_acc;
    logic [VALUE_W-1:0] s_acc;
    int                 r_digits;
    int                 s_digits;
    bit                 nz_seen;
    bit                 bad;

    sig_beat_t  pending_beats[$];   // beats owed by the DUT, oldest first
    logic [7:0] sig_bytes[$];       // the stream being built or sent
    int         mismatches;
    int         cycle_count;
    int         random_sent;
    bit         tx_idle_on;
    bit         rx_idle_on;
    int         hold_req;           // a long receiver hold-off asked by the stimulus
    int         rx_wait;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic void parser_clear();
        ph       = PH_SEQ_TAG;
        len_cnt  = 0;
        lol      = '0;
        r_acc    = '0;
        s_acc    = '0;
        r_digits = 0;
        s_digits = 0;
        nz_seen  = 1'b0;
        bad      = 1'b0;
    endfunction

    // A value with a zero length is done at once; the parser moves to the S tag, or to done after S.
    function automatic void open_body(bit second);
        nz_seen = 1'b0;
        if (len_cnt == 0)
            ph = second ? PH_DONE : PH_S_TAG;
        else
            ph = second ? PH_S_BODY : PH_R_BODY;
    endfunction

    function automatic void take_length(bit second, logic [7:0] b);
        if (b[7])
        begin
            lol     = {1'b0, b[6:0]};
            len_cnt = 0;
            nz_seen = 1'b0;
            if (lol == 0)
                open_body(second);
            else
                ph = second ? PH_S_LONG : PH_R_LONG;
        end
        else
        begin
            len_cnt = b;
            open_body(second);
        end
    endfunction

    // Leading zero length bytes only count down; the first nonzero one checks how many remain.
    function automatic void take_long_length(bit second, logic [7:0] b);
        int unsigned t;
        if (!nz_seen && b == 8'h00)
            lol--;
        else
        begin
            if (!nz_seen)
            begin
                if (lol >= LEN_OF_LEN_LIMIT)
                begin
                    bad = 1'b1;
                    return;
                end
                nz_seen = 1'b1;
            end
            t       = len_cnt * 256 + b;
            len_cnt = (t > STREAM_BOUND) ? STREAM_BOUND : t;
            lol--;
        end
        if (lol == 0)
            open_body(second);
    endfunction

    // Significant bytes shift in from the right; a 33rd one marks the value oversize.
    function automatic void take_digit(bit second, logic [7:0] b);
        len_cnt--;
        if (nz_seen || b != 8'h00)
        begin
            nz_seen = 1'b1;
            if (second)
            begin
                if (s_digits < INT_BYTES)
                begin
                    s_acc = {s_acc[VALUE_W-9:0], b};
                    s_digits++;
                end
                else
                    s_digits = INT_BYTES + 1;
            end
            else
            begin
                if (r_digits < INT_BYTES)
                begin
                    r_acc = {r_acc[VALUE_W-9:0], b};
                    r_digits++;
                end
                else
                    r_digits = INT_BYTES + 1;
            end
        end
        if (len_cnt == 0)
            ph = second ? PH_DONE : PH_S_TAG;
    endfunction

    function automatic void parse_byte(logic [7:0] b);
        if (bad)
            return;
        case (ph)
            PH_SEQ_TAG:
                if (b != SEQ_TAG) bad = 1'b1; else ph = PH_SEQ_LEN;
            PH_SEQ_LEN:
            begin
                len_cnt = b[7] ? int'(b[6:0]) : 0;
                ph      = (len_cnt != 0) ? PH_SEQ_SKIP : PH_R_TAG;
            end
            PH_SEQ_SKIP:
            begin
                len_cnt--;
                if (len_cnt == 0)
                    ph = PH_R_TAG;
            end
            PH_R_TAG:
                if (b != INT_TAG) bad = 1'b1; else ph = PH_R_LEN;
            PH_S_TAG:
                if (b != INT_TAG) bad = 1'b1; else ph = PH_S_LEN;
            PH_R_LEN:   take_length(1'b0, b);
            PH_S_LEN:   take_length(1'b1, b);
            PH_R_LONG:  take_long_length(1'b0, b);
            PH_S_LONG:  take_long_length(1'b1, b);
            PH_R_BODY:  take_digit(1'b0, b);
            PH_S_BODY:  take_digit(1'b1, b);
            default:    ;
        endcase
    endfunction

    // On the final byte: queue the eight beats, typed in or predicted, and restart the parser.
    function automatic void close_signature(check_t chk);
        bit        ok;
        bit        oor;
        sig_beat_t beat;
        ok  = !bad && ph == PH_DONE;
        oor = ok && (r_digits > INT_BYTES || s_digits > INT_BYTES ||
                     r_acc >= GROUP_ORDER || s_acc >= GROUP_ORDER);
        for (int k = 0; k < WORDS; k++)
        begin
            beat.idx  = k[IDX_W-1:0];
            beat.last = (k == WORDS - 1);
            beat.word = '0;
            if (chk == CHK_MODEL)
            begin
                beat.ok  = ok;
                beat.oor = oor;
                if (ok && !oor)
                    beat.word = (k < WORDS / 2) ? r_acc[VALUE_W-1-WORD_W*k -: WORD_W]
                                                : s_acc[VALUE_W-1-WORD_W*(k-4) -: WORD_W];
            end
            else
            begin
                beat.ok  = (chk != CHK_REJECT);
                beat.oor = (chk == CHK_OOR);
            end
            pending_beats.push_back(beat);
        end
        parser_clear();
    endfunction

    // ------------------------------------------------------------------
    // Stream builder
    // ------------------------------------------------------------------
    function automatic void push_int(int_spec_t v);
        logic [7:0]         body[$];
        logic [VALUE_W-1:0] val;
        int                 total;
        int                 nmin;
        int                 nb;
        repeat (v.pad) body.push_back(8'h00);
        case (v.kind)
            VK_ORDER, VK_ORDER_LESS:
            begin
                val = (v.kind == VK_ORDER) ? GROUP_ORDER : GROUP_ORDER - 1;
                for (int i = INT_BYTES - 1; i >= 0; i--)
                    body.push_back(val[8*i +: 8]);
            end
            VK_ALL_FF:
                repeat (v.nbytes) body.push_back(8'hFF);
            default:
                for (int i = 0; i < v.nbytes; i++)
                    body.push_back((i == 0) ? 8'($urandom_range(1, 255))
                                            : 8'($urandom_range(0, 255)));
        endcase
        total = body.size();
        sig_bytes.push_back(v.tag);
        if (v.len_huge != 0)
        begin
            sig_bytes.push_back(8'h80 | v.len_huge);
            repeat (v.len_huge) sig_bytes.push_back(8'hFF);
        end
        else if (!v.long_len)
            sig_bytes.push_back(total[7:0]);
        else
        begin
            nmin = 0;
            for (int t = total; t != 0; t = t >> 8)
                nmin++;
            nb = nmin + v.len_pad;
            sig_bytes.push_back(8'h80 | nb[7:0]);
            for (int i = nb - 1; i >= 0; i--)
                sig_bytes.push_back((i < 4) ? total[8*i +: 8] : 8'h00);
        end
        foreach (body[i])
            sig_bytes.push_back(body[i]);
    endfunction

    function automatic void build_stream(sig_spec_t sp);
        sig_bytes.delete();
        sig_bytes.push_back(sp.seq_tag);
        if (sp.seq_skip == 0)
            sig_bytes.push_back(8'($urandom_range(0, 128)));   // 0x80 is an empty long form
        else
        begin
            sig_bytes.push_back(8'h80 | sp.seq_skip);
            repeat (sp.seq_skip) sig_bytes.push_back(8'($urandom_range(0, 255)));
        end
        push_int(sp.r);
        push_int(sp.s);
        repeat (sp.trail) sig_bytes.push_back(8'($urandom_range(0, 255)));
        if (sp.cut != 0 && sp.cut < sig_bytes.size())
            sig_bytes = sig_bytes[0:sp.cut-1];
    endfunction

    function automatic int_spec_t rand_int();
        int_spec_t v;
        int        pick;
        pick       = $urandom_range(0, 15);
        v.tag      = INT_TAG;
        v.kind     = (pick == 0) ? VK_ALL_FF : (pick == 1) ? VK_ORDER :
                     (pick == 2) ? VK_ORDER_LESS : VK_RANDOM;
        if (v.kind == VK_ALL_FF)
            v.nbytes = $urandom_range(1, 33);
        else
            v.nbytes = ($urandom_range(0, 7) == 0) ? $urandom_range(29, 33)
                                                   : $urandom_range(0, 8);
        v.pad      = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
        v.long_len = ($urandom_range(0, 2) == 0);
        v.len_pad  = (v.long_len && $urandom_range(0, 1) == 1) ? $urandom_range(1, 7) : 0;
        v.len_huge = 0;
        return v;
    endfunction

    function automatic sig_spec_t rand_sig();
        sig_spec_t sp;
        sp.seq_tag  = SEQ_TAG;
        sp.seq_skip = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
        sp.r        = rand_int();
        sp.s        = rand_int();
        sp.trail    = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
        sp.cut      = 0;
        sp.chk      = CHK_MODEL;
        return sp;
    endfunction

    // ------------------------------------------------------------------
    // Byte sender. Every byte is predicted when its beat is taken.
    // ------------------------------------------------------------------
    task automatic send_stream(check_t chk);
        int gap;
        foreach (sig_bytes[i])
        begin
            gap = tx_idle_on ? $urandom_range(0, 3) : 0;
            if (gap != 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= sig_bytes[i];
            s_tlast  <= (i == sig_bytes.size() - 1);
            do
                @(posedge clk);
            while (!s_tready);
            parse_byte(sig_bytes[i]);
            if (i == sig_bytes.size() - 1)
                close_signature(chk);
        end
    endtask

    // Stop offering bytes, wait for every owed beat, then let the pipeline run empty.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_beats.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Receiver: a random stall after each beat while idling is on, or a long hold-off on request.
    // ------------------------------------------------------------------
    initial
    begin
        m_tready <= 1'b0;
        rx_wait = 0;
        forever
        begin
            @(posedge clk);
            if (!rst_n)
                m_tready <= 1'b0;
            else
            begin
                if (hold_req != 0)
                begin
                    rx_wait  = hold_req;
                    hold_req = 0;
                end
                else if (m_tvalid && m_tready)
                    rx_wait = rx_idle_on ? $urandom_range(0, 3) : 0;
                else if (rx_wait != 0)
                    rx_wait--;
                m_tready <= (rx_wait == 0);
            end
        end
    end

    // Output checker: every taken beat against the oldest owed one.
    always @(posedge clk)
    begin
        sig_beat_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_beats.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: word %h index %0d", m_tdata[63:0],
                             m_tdata[66:64]);
            end
            else
            begin
                want = pending_beats.pop_front();
                if (m_tdata[63:0] !== want.word || m_tdata[66:64] !== want.idx ||
                    m_tuser[0] !== want.ok || m_tuser[1] !== want.oor ||
                    m_tlast !== want.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("beat mismatch: expected %h idx %0d ok %b oor %b last %b,%s",
                                 want.word, want.idx, want.ok, want.oor, want.last,
                                 $sformatf(" got %h idx %0d ok %b oor %b last %b",
                                           m_tdata[63:0], m_tdata[66:64], m_tuser[0],
                                           m_tuser[1], m_tlast));
                end
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout with %0d beats outstanding", pending_beats.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin
        sig_spec_t sp;
        int        pick;
        rst_n      <= 1'b0;
        s_tvalid   <= 1'b0;
        s_tdata    <= '0;
        s_tlast    <= 1'b0;
        mismatches  = 0;
        cycle_count = 0;
        random_sent = 0;
        hold_req    = 0;
        tx_idle_on  = 1'b1;
        rx_idle_on  = 1'b1;
        parser_clear();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed cases, with idling switched on or off per signature.
        foreach (DIRECTED_CASES[i])
        begin
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on = ($urandom_range(0, 3) != 0);
            build_stream(DIRECTED_CASES[i]);
            send_stream(DIRECTED_CASES[i].chk);
        end
        settle();

        // Back-pressure: the receiver holds off while the sender keeps offering bytes, so the
        // output bank fills and the input side stalls. Afterwards the sender waits for all beats.
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b1;
        hold_req   = HOLD_CYCLES;
        repeat (6)
        begin
            build_stream(rand_sig());
            send_stream(CHK_MODEL);
        end
        settle();

        // Random part: mostly well-formed signatures, some broken ones and some plain noise.
        while (random_sent < RANDOM_BYTES)
        begin
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on = ($urandom_range(0, 3) != 0);
            pick       = $urandom_range(0, 9);
            if (pick == 0)
            begin
                sig_bytes.delete();
                repeat ($urandom_range(1, 12)) sig_bytes.push_back(8'($urandom_range(0, 255)));
                if ($urandom_range(0, 1) == 1)
                    sig_bytes[0] = SEQ_TAG;
            end
            else
            begin
                sp = rand_sig();
                if (pick <= 2)
                begin
                    case ($urandom_range(0, 4))
                        0: sp.seq_tag = $urandom_range(0, 255);
                        1: sp.r.tag = $urandom_range(0, 255);
                        2: sp.s.tag = $urandom_range(0, 255);
                        3: if ($urandom_range(0, 1) == 1) sp.r.len_huge = $urandom_range(1, 9);
                           else sp.s.len_huge = $urandom_range(1, 9);
                        default: sp.cut = $urandom_range(1, 60);
                    endcase
                end
                build_stream(sp);
            end
            random_sent += sig_bytes.size();
            send_stream(CHK_MODEL);
        end
        settle();

        if (pending_beats.size() != 0)
        begin
            mismatches++;
            $display("%0d beats never arrived", pending_beats.size());
        end
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- der_signature_lax_parser.f -----
sv/dslp_pkg.sv
sv/dslp_parser.sv
sv/dslp_emitter.sv
sv/der_signature_lax_parser.sv
tb/sv/testbench.sv
